// ===== hdl/gpio_pkg.sv =====
// Shared types, codes and helper functions of the GPIO port with interrupt detection.
package gpio_pkg;

    // Default pin count of the port.
    localparam int PIN_COUNT_DEF = 32;

    // Width of the register data path and of every pin vector.
    localparam int DATA_W = 32;

    // Bus access codes.
    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;

    // Register map variants.
    localparam logic [1:0] VARIANT_OLD  = 2'd0;
    localparam logic [1:0] VARIANT_MID  = 2'd1;
    localparam logic [1:0] VARIANT_ESEL = 2'd2;

    // Byte offsets of the oldest register map.
    localparam logic [5:0] OLD_OFS_GDIR = 6'h00;
    localparam logic [5:0] OLD_OFS_DR   = 6'h1c;
    localparam logic [5:0] OLD_OFS_PSR  = 6'h24;
    localparam logic [5:0] OLD_OFS_ICR1 = 6'h28;
    localparam logic [5:0] OLD_OFS_ICR2 = 6'h2c;
    localparam logic [5:0] OLD_OFS_IMR  = 6'h30;
    localparam logic [5:0] OLD_OFS_ISR  = 6'h34;

    // Byte offsets of the newer register maps.
    localparam logic [5:0] MID_OFS_DR   = 6'h00;
    localparam logic [5:0] MID_OFS_GDIR = 6'h04;
    localparam logic [5:0] MID_OFS_PSR  = 6'h08;
    localparam logic [5:0] MID_OFS_ICR1 = 6'h0c;
    localparam logic [5:0] MID_OFS_ICR2 = 6'h10;
    localparam logic [5:0] MID_OFS_IMR  = 6'h14;
    localparam logic [5:0] MID_OFS_ISR  = 6'h18;
    localparam logic [5:0] MID_OFS_ESEL = 6'h1c;

    // Decoded register selects.
    typedef enum logic [3:0] {
        REG_DR,
        REG_GDIR,
        REG_PSR,
        REG_ICR1,
        REG_ICR2,
        REG_IMR,
        REG_ISR,
        REG_ESEL,
        REG_NONE
    } t_reg;

    // Kinds of trigger condition.
    typedef enum logic [1:0] {
        K_LOW,
        K_HIGH,
        K_RISE,
        K_FALL
    } t_kind;

    // Per-pin inputs of one detection lane.
    typedef struct packed {
        logic       now;
        logic       prev;
        logic [1:0] code;
        logic       oldest;
        logic       both_edge;
    } t_lane_in;

    // Interrupt lines produced by the merge stage.
    typedef struct packed {
        logic low_half;
        logic high_half;
        logic any;
    } t_irq;

    // Map a 2-bit trigger code to its kind for the selected encoding.
    function automatic t_kind code_kind(input logic oldest, input logic [1:0] code);
        t_kind k;
        case (code)
            2'd0:    k = oldest ? K_RISE : K_LOW;
            2'd1:    k = oldest ? K_FALL : K_HIGH;
            2'd2:    k = oldest ? K_HIGH : K_RISE;
            default: k = oldest ? K_LOW  : K_FALL;
        endcase
        return k;
    endfunction

endpackage

// ===== hdl/gpio_lane.sv =====
// One detection lane: checks a single pin against its trigger condition.
module gpio_lane (
    input  gpio_pkg::t_lane_in i_lane,
    output logic               o_hit
);
    import gpio_pkg::*;

    // Both-edge select overrides the trigger code; otherwise decode the code.
    always_comb begin
        if (i_lane.both_edge) begin
            o_hit = i_lane.now ^ i_lane.prev;
        end else begin
            case (code_kind(i_lane.oldest, i_lane.code))
                K_LOW:   o_hit = ~i_lane.now;
                K_HIGH:  o_hit = i_lane.now;
                K_RISE:  o_hit = i_lane.now & ~i_lane.prev;
                default: o_hit = ~i_lane.now & i_lane.prev;
            endcase
        end
    end

endmodule

// ===== hdl/gpio_irq_merge.sv =====
// Merge stage: folds the masked pending bits of all lanes into interrupt lines.
module gpio_irq_merge (
    input  logic [gpio_pkg::DATA_W-1:0] i_pending,
    output gpio_pkg::t_irq              o_irq
);
    import gpio_pkg::*;

    localparam int HALF_W = DATA_W / 2;

    // Reduce each half, then combine the halves.
    always_comb begin
        o_irq.low_half  = |i_pending[HALF_W-1:0];
        o_irq.high_half = |i_pending[DATA_W-1:HALF_W];
        o_irq.any       = o_irq.low_half | o_irq.high_half;
    end

endmodule

// ===== hdl/gpio_port_with_interrupt_detect_unit.sv =====
// Top level of the GPIO port: register file, detection lanes and output stage.
// A result item appears in the cycle after its input item is accepted.
// Throughput: one item per cycle; the single output register is the only stage,
// and the input is ready whenever that register is empty or being emptied.
// Reset (synchronous, active low) clears all port registers and the previous
// pad levels, empties the output stage and sets the variant register to 2.
module gpio_port_with_interrupt_detect_unit #(
    parameter int PIN_COUNT = gpio_pkg::PIN_COUNT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_mode,
    input  logic [5:0]                  i_address,
    input  logic [gpio_pkg::DATA_W-1:0] i_write_data,
    input  logic [gpio_pkg::DATA_W-1:0] i_pad_levels,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [gpio_pkg::DATA_W-1:0] o_read_data,
    output logic [gpio_pkg::DATA_W-1:0] o_pad_drive,
    output logic [gpio_pkg::DATA_W-1:0] o_pad_output_enable,
    output logic                        o_irq_low_half,
    output logic                        o_irq_high_half,
    output logic                        o_irq_any
);
    import gpio_pkg::*;

    localparam logic [DATA_W-1:0] PinMask = {DATA_W{1'b1}} >> (DATA_W - PIN_COUNT);
    localparam int HALF_W = DATA_W / 2;

    // Address decode for the active register map.
    function automatic t_reg decode(input logic [1:0] variant, input logic [5:0] addr);
        logic [5:0] a;
        t_reg       r;
        a = {addr[5:2], 2'b00};
        if (variant == VARIANT_OLD) begin
            case (a)
                OLD_OFS_GDIR: r = REG_GDIR;
                OLD_OFS_DR:   r = REG_DR;
                OLD_OFS_PSR:  r = REG_PSR;
                OLD_OFS_ICR1: r = REG_ICR1;
                OLD_OFS_ICR2: r = REG_ICR2;
                OLD_OFS_IMR:  r = REG_IMR;
                OLD_OFS_ISR:  r = REG_ISR;
                default:      r = REG_NONE;
            endcase
        end else begin
            case (a)
                MID_OFS_DR:   r = REG_DR;
                MID_OFS_GDIR: r = REG_GDIR;
                MID_OFS_PSR:  r = REG_PSR;
                MID_OFS_ICR1: r = REG_ICR1;
                MID_OFS_ICR2: r = REG_ICR2;
                MID_OFS_IMR:  r = REG_IMR;
                MID_OFS_ISR:  r = REG_ISR;
                MID_OFS_ESEL: r = (variant == VARIANT_ESEL) ? REG_ESEL : REG_NONE;
                default:      r = REG_NONE;
            endcase
        end
        return r;
    endfunction

    // Port state.
    logic [1:0]        r_variant;
    logic [DATA_W-1:0] r_dr, r_gdir, r_icr1, r_icr2, r_imr, r_isr, r_esel, r_prev;
    logic [DATA_W-1:0] n_dr, n_gdir, n_icr1, n_icr2, n_imr, n_isr, n_esel;

    // Output stage.
    logic              r_out_valid;
    logic [DATA_W-1:0] r_read_data, r_pad_drive, r_pad_oe;
    logic              r_irq_low, r_irq_high, r_irq_any;
    logic [DATA_W-1:0] n_read_data;

    logic              in_fire;
    logic [DATA_W-1:0] cur_pads;
    logic [DATA_W-1:0] hits;
    logic [DATA_W-1:0] clr;
    t_reg              reg_sel;
    t_irq              irq;

    assign o_in_ready = ~r_out_valid | i_out_ready;
    assign in_fire    = i_in_valid & o_in_ready;
    assign cur_pads   = i_pad_levels & PinMask;
    assign reg_sel    = (i_mode == MODE_READ || i_mode == MODE_WRITE) ?
                        decode(r_variant, i_address) : REG_NONE;

    // Detection lanes, one per implemented pin.
    for (genvar g = 0; g < DATA_W; g++) begin : g_lane
        if (g < PIN_COUNT) begin : g_used
            t_lane_in lane_in;
            always_comb begin
                lane_in.now       = cur_pads[g];
                lane_in.prev      = r_prev[g];
                lane_in.oldest    = (r_variant == VARIANT_OLD);
                lane_in.both_edge = (r_variant == VARIANT_ESEL) & r_esel[g];
                if (g < HALF_W) begin
                    lane_in.code = r_icr1[(g % HALF_W) * 2 +: 2];
                end else begin
                    lane_in.code = r_icr2[(g % HALF_W) * 2 +: 2];
                end
            end
            gpio_lane u_lane (
                .i_lane (lane_in),
                .o_hit  (hits[g])
            );
        end else begin : g_unused
            assign hits[g] = 1'b0;
        end
    end

    // Register read mux; reads see the state before this item's update.
    always_comb begin
        n_read_data = '0;
        if (i_mode == MODE_READ) begin
            case (reg_sel)
                REG_DR:   n_read_data = r_dr;
                REG_GDIR: n_read_data = r_gdir;
                REG_PSR:  n_read_data = cur_pads;
                REG_ICR1: n_read_data = r_icr1;
                REG_ICR2: n_read_data = r_icr2;
                REG_IMR:  n_read_data = r_imr;
                REG_ISR:  n_read_data = r_isr;
                REG_ESEL: n_read_data = r_esel;
                default:  n_read_data = '0;
            endcase
        end
    end

    // Register writes and status update; a detection wins over a clear.
    always_comb begin
        n_dr   = r_dr;
        n_gdir = r_gdir;
        n_icr1 = r_icr1;
        n_icr2 = r_icr2;
        n_imr  = r_imr;
        n_esel = r_esel;
        clr    = '0;
        if (i_mode == MODE_WRITE) begin
            case (reg_sel)
                REG_DR:   n_dr   = i_write_data & PinMask;
                REG_GDIR: n_gdir = i_write_data & PinMask;
                REG_ICR1: n_icr1 = i_write_data;
                REG_ICR2: n_icr2 = i_write_data;
                REG_IMR:  n_imr  = i_write_data & PinMask;
                REG_ISR:  clr    = i_write_data;
                REG_ESEL: n_esel = i_write_data & PinMask;
                default:  clr    = '0;
            endcase
        end
        n_isr = ((r_isr & ~clr) | hits) & PinMask;
    end

    // Merge the lanes' pending bits into interrupt lines.
    gpio_irq_merge u_merge (
        .i_pending (n_isr & n_imr),
        .o_irq     (irq)
    );

    // Variant register; a write of the unused code selects the newest map.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_variant <= VARIANT_ESEL;
        end else if (i_cfg_we) begin
            r_variant <= (i_cfg_data > VARIANT_ESEL) ? VARIANT_ESEL : i_cfg_data;
        end
    end

    // Port state update on each accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dr   <= '0;
            r_gdir <= '0;
            r_icr1 <= '0;
            r_icr2 <= '0;
            r_imr  <= '0;
            r_isr  <= '0;
            r_esel <= '0;
            r_prev <= '0;
        end else if (in_fire) begin
            r_dr   <= n_dr;
            r_gdir <= n_gdir;
            r_icr1 <= n_icr1;
            r_icr2 <= n_icr2;
            r_imr  <= n_imr;
            r_isr  <= n_isr;
            r_esel <= n_esel;
            r_prev <= cur_pads;
        end
    end

    // Output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload, loaded with each accepted item.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_read_data <= n_read_data;
            r_pad_drive <= n_dr;
            r_pad_oe    <= n_gdir;
            r_irq_low   <= irq.low_half;
            r_irq_high  <= irq.high_half;
            r_irq_any   <= irq.any;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_read_data         = r_read_data;
    assign o_pad_drive         = r_pad_drive;
    assign o_pad_output_enable = r_pad_oe;
    assign o_irq_low_half      = r_irq_low;
    assign o_irq_high_half     = r_irq_high;
    assign o_irq_any           = r_irq_any;

    // The unused variant code never reaches the register.
    a_variant_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_variant != 2'd3)
        else $error("variant register holds an unused code");

    // Status bits of pins beyond the port width stay clear.
    a_status_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_isr & ~PinMask) == '0)
        else $error("status bit set beyond the pin count");

    // Every detected pin is latched in the status register after the item.
    a_hit_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> ((r_isr & $past(hits)) == $past(hits)))
        else $error("detected pin not latched in status");

    // The combined interrupt agrees with the two halves of a valid result.
    a_irq_merge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_irq_any == (o_irq_low_half | o_irq_high_half)))
        else $error("combined interrupt disagrees with its halves");

endmodule
